// ----- rtl/bitmap_run_allocator_unit_macros.svh -----
// Assertion helpers for the asserting top-level file.
`ifndef BITMAP_RUN_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_RUN_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BRA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BRA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bra_pkg.sv -----
package bra_pkg;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_TEST  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_FIND  = 2'd3;

    localparam logic       REG_BYTES_IN_USE = 1'b0;
    localparam logic [7:0] BYTES_RESET      = 8'd128;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  unit_idx;
        logic        bit_value;
        logic [10:0] run_length;
    } t_in;

    typedef struct packed {
        logic       bit_used;
        logic       found;
        logic [9:0] run_start;
        logic       index_error;
    } t_out;

    typedef struct packed {
        logic load;
        logic sweep;
        logic rd_idx;
        logic wr_idx;
        logic find_rd;
        logic scan;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       nbytes_zero;
        logic       in_range;
        logic       find_ok;
        logic       last_used;
        logic       last_max;
        logic       eval_last;
        logic       hit;
    } t_status;

endpackage

// ----- rtl/bra_ram.sv -----
module bra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bra_ctrl.sv -----
module bra_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  bra_pkg::t_status i_status,
    output bra_pkg::t_cmd    o_cmd,
    output logic             o_busy
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_TEST   = 3'd3;
    localparam logic [2:0] S_WRITE  = 3'd4;
    localparam logic [2:0] S_CLEAR  = 3'd5;
    localparam logic [2:0] S_FIND   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                // zero the whole store once after reset
                o_cmd.sweep = 1'b1;
                if (i_status.last_max) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_status.op)
                    bra_pkg::OP_CLEAR: begin
                        if (i_status.nbytes_zero) begin
                            o_cmd.finish = 1'b1;
                            n_state      = S_IDLE;
                        end else begin
                            n_state = S_CLEAR;
                        end
                    end
                    bra_pkg::OP_TEST: begin
                        if (i_status.in_range) begin
                            o_cmd.rd_idx = 1'b1;
                            n_state      = S_TEST;
                        end else begin
                            o_cmd.finish = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                    bra_pkg::OP_WRITE: begin
                        if (i_status.in_range) begin
                            o_cmd.rd_idx = 1'b1;
                            n_state      = S_WRITE;
                        end else begin
                            o_cmd.finish = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                    bra_pkg::OP_FIND: begin
                        if (i_status.find_ok) begin
                            o_cmd.find_rd = 1'b1;
                            n_state       = S_FIND;
                        end else begin
                            o_cmd.finish = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                    default: begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end
                endcase
            end
            S_TEST: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            S_WRITE: begin
                o_cmd.wr_idx = 1'b1;
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            S_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_status.last_used) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_FIND: begin
                // evaluate the byte read last cycle, fetch the next one
                o_cmd.scan    = 1'b1;
                o_cmd.find_rd = 1'b1;
                if (i_status.hit || i_status.eval_last) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- rtl/bra_dpath.sv -----
module bra_dpath #(
    parameter int MAX_BYTES = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bra_pkg::t_in     i_item,
    input  logic [7:0]       i_bytes_in_use,
    input  bra_pkg::t_cmd    i_cmd,
    output bra_pkg::t_status o_status,
    output logic             o_done,
    output bra_pkg::t_out    o_result
);

    localparam int AW  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int NBW = $clog2(MAX_BYTES + 1);
    localparam int CW  = (NBW > 8) ? NBW : 8;
    localparam int UW  = NBW + 3;
    localparam int XW  = (UW > 11) ? UW : 11;

    bra_pkg::t_in  r_item;
    bra_pkg::t_out r_result;
    bra_pkg::t_out n_result;
    logic          r_done;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_eval_byte;
    logic          r_eval_last;
    logic [10:0]   r_count;
    logic [9:0]    r_cand;

    logic [CW-1:0]  cfg_ext;
    logic [CW-1:0]  nbytes_sat;
    logic [NBW-1:0] nbytes;
    logic [UW-1:0]  units;
    logic           in_range;
    logic           find_ok;
    logic           last_used;
    logic [AW-1:0]  idx_byte;
    logic [7:0]     ram_q;
    logic [7:0]     ram_wdata;
    logic [7:0]     byte_mod;
    logic [AW-1:0]  ram_waddr;
    logic [AW-1:0]  ram_raddr;
    logic           ram_we;

    logic [10:0]    scan_cnt;
    logic [9:0]     scan_cand;
    logic           scan_hit;
    logic [9:0]     scan_start;

    // saturate the register to the store depth
    assign cfg_ext    = CW'(i_bytes_in_use);
    assign nbytes_sat = (cfg_ext > CW'(MAX_BYTES)) ? CW'(MAX_BYTES) : cfg_ext;
    assign nbytes     = NBW'(nbytes_sat);
    assign units      = {nbytes, 3'b000};

    assign in_range  = XW'(r_item.unit_idx) < XW'(units);
    assign find_ok   = (r_item.run_length != 11'd0) && (XW'(r_item.run_length) <= XW'(units));
    assign last_used = (NBW'(r_addr) + NBW'(1)) == nbytes;
    assign idx_byte  = AW'(r_item.unit_idx[9:3]);

    always_comb begin
        byte_mod = ram_q;
        byte_mod[r_item.unit_idx[2:0]] = r_item.bit_value;
    end

    assign ram_we    = i_cmd.sweep | i_cmd.wr_idx;
    assign ram_waddr = i_cmd.wr_idx ? idx_byte : r_addr;
    assign ram_wdata = i_cmd.wr_idx ? byte_mod : 8'd0;
    assign ram_raddr = i_cmd.rd_idx ? idx_byte : r_addr;

    bra_ram #(
        .WIDTH (8),
        .DEPTH (MAX_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // walk the eight units of one byte, carrying the free-run count
    always_comb begin
        logic [AW+2:0] unit;
        scan_cnt   = r_count;
        scan_cand  = r_cand;
        scan_hit   = 1'b0;
        scan_start = 10'd0;
        unit       = '0;
        for (int b = 0; b < 8; b++) begin
            unit = {r_eval_byte, 3'(b)};
            if (!scan_hit) begin
                if (ram_q[b]) begin
                    scan_cnt = 11'd0;
                end else begin
                    if (scan_cnt == 11'd0) begin
                        scan_cand = 10'(unit);
                    end
                    scan_cnt = scan_cnt + 11'd1;
                    if (scan_cnt == r_item.run_length) begin
                        scan_hit   = 1'b1;
                        scan_start = scan_cand;
                    end
                end
            end
        end
    end

    always_comb begin
        n_result.bit_used    = (r_item.op == bra_pkg::OP_TEST) && in_range
                               && ram_q[r_item.unit_idx[2:0]];
        n_result.found       = i_cmd.scan && scan_hit;
        n_result.run_start   = (i_cmd.scan && scan_hit) ? scan_start : 10'd0;
        n_result.index_error = ((r_item.op == bra_pkg::OP_TEST)
                                || (r_item.op == bra_pkg::OP_WRITE)) && !in_range;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cmd.load) begin
                r_addr <= '0;
            end else if (i_cmd.sweep) begin
                r_addr <= r_addr + AW'(1);
            end else if (i_cmd.find_rd && !last_used) begin
                r_addr <= r_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item  <= i_item;
            r_count <= 11'd0;
            r_cand  <= 10'd0;
        end else if (i_cmd.scan) begin
            r_count <= scan_cnt;
            r_cand  <= scan_cand;
        end
        if (i_cmd.find_rd) begin
            r_eval_byte <= r_addr;
            r_eval_last <= last_used;
        end
        if (i_cmd.finish) begin
            r_result <= n_result;
        end
    end

    always_comb begin
        o_status.op          = r_item.op;
        o_status.nbytes_zero = (nbytes == '0);
        o_status.in_range    = in_range;
        o_status.find_ok     = find_ok;
        o_status.last_used   = last_used;
        o_status.last_max    = (r_addr == AW'(MAX_BYTES - 1));
        o_status.eval_last   = r_eval_last;
        o_status.hit         = scan_hit;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ----- rtl/bitmap_run_allocator_unit.sv -----
// Channel    Direction  Handshake                     Payload
// item       in         start high, busy low          i_item (op, index, value, length)
// result     out        o_done strobe, one cycle      o_result
// config     in/out     APB, write on access phase    pwdata[7:0] bytes_in_use
//
// Test and write in range read the indexed byte after decode and then finish; an item
// settled at decode (index out of range, nothing to clear, no run possible) finishes there;
// clear sweeps each managed byte in turn; find reads byte after byte until a run is found
// or the last managed byte is evaluated. The single read port of the bitmap store allows
// one byte per cycle. After reset the store is swept to zero with busy held high.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "bitmap_run_allocator_unit_macros.svh"

module bitmap_run_allocator_unit #(
    parameter int MAX_BYTES = 128
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  bra_pkg::t_in   i_item,
    output logic           busy,
    output logic           o_done,
    output bra_pkg::t_out  o_result,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    logic             sel_bytes;
    logic [7:0]       r_bytes;
    bra_pkg::t_cmd    cmd;
    bra_pkg::t_status status;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign sel_bytes = (paddr[2] == bra_pkg::REG_BYTES_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes <= bra_pkg::BYTES_RESET;
        end else if (cfg_wr && sel_bytes) begin
            r_bytes <= pwdata[7:0];
        end
    end

    assign prdata = sel_bytes ? {24'd0, r_bytes} : 32'd0;

    bra_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    bra_dpath #(
        .MAX_BYTES (MAX_BYTES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_bytes_in_use (r_bytes),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_done         (o_done),
        .o_result       (o_result)
    );

    `BRA_ASSERT_IMP(a_done_after_busy, o_done, $past(busy), "result strobe without work in hand")
    `BRA_ASSERT_NXT(a_accept_goes_busy, start && !busy, busy, "accepted item did not raise busy")
    `BRA_ASSERT_IMP(a_no_start_when_missed, o_done && !o_result.found,
                    o_result.run_start == 10'd0, "run start set without a run found")
    `BRA_ASSERT_IMP(a_found_clean, o_done && o_result.found,
                    !o_result.index_error && !o_result.bit_used, "find result mixed with test fields")

endmodule

// ----- tb/tb.sv -----
module tb;

    localparam int MAP_BYTES   = 128;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = MAP_BYTES + 16;
    localparam int PHASE_ITEMS = 150;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    bra_pkg::t_in  i_item;
    logic          busy;
    logic          o_done;
    bra_pkg::t_out o_result;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    // Shadow of the allocator: usage bitmap and the size register
    logic [7:0]    usage_map [MAP_BYTES];
    logic [7:0]    bytes_reg;
    bra_pkg::t_out pending_results [$];
    int            mismatches;
    int            stall_cycles;

    bitmap_run_allocator_unit #(
        .MAX_BYTES(MAP_BYTES)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int managed_bytes();
        return (int'(bytes_reg) > MAP_BYTES) ? MAP_BYTES : int'(bytes_reg);
    endfunction

    // Apply one operation to the shadow map and return the result it gives
    function automatic bra_pkg::t_out apply_to_map(input bra_pkg::t_in it);
        bra_pkg::t_out r;
        int   nb;
        int   units;
        int   b;
        int   u;
        int   cnt;
        logic hit;
        r = '0;
        nb = managed_bytes();
        units = nb * 8;
        case (it.op)
            bra_pkg::OP_CLEAR: begin
                for (b = 0; b < nb; b++) usage_map[b] = 8'h00;
            end
            bra_pkg::OP_TEST: begin
                if (int'(it.unit_idx) >= units) r.index_error = 1'b1;
                else r.bit_used = usage_map[it.unit_idx[9:3]][it.unit_idx[2:0]];
            end
            bra_pkg::OP_WRITE: begin
                if (int'(it.unit_idx) >= units) r.index_error = 1'b1;
                else usage_map[it.unit_idx[9:3]][it.unit_idx[2:0]] = it.bit_value;
            end
            bra_pkg::OP_FIND: begin
                if (it.run_length != 11'd0 && int'(it.run_length) <= units) begin
                    // skip full bytes, bounded by the managed size
                    b = 0;
                    while (b < nb && usage_map[b] == 8'hff) b++;
                    cnt = 0;
                    hit = 1'b0;
                    for (u = b * 8; u < units && !hit; u++) begin
                        if (usage_map[u / 8][u % 8]) cnt = 0;
                        else cnt++;
                        if (cnt == int'(it.run_length)) begin
                            hit = 1'b1;
                            r.found = 1'b1;
                            r.run_start = 10'(u + 1 - cnt);
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic bra_pkg::t_in op_item(input logic [1:0] op, input int idx,
                                             input logic val, input int len);
        bra_pkg::t_in it;
        it.op = op;
        it.unit_idx = 10'(idx);
        it.bit_value = val;
        it.run_length = 11'(len);
        return it;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(30, 150);
    endfunction

    // Offer one item after an idle gap; hold it until the transfer
    task automatic send_op(input bra_pkg::t_in it, input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(apply_to_map(it));
    endtask

    // Drop start and wait for every outstanding result and an idle block
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic write_bytes_in_use(input logic [7:0] value);
        logic [31:0] word;
        settle();
        word = $urandom();
        word[7:0] = value;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(bra_pkg::REG_BYTES_IN_USE) << 2;
        pwdata <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        bytes_reg = value;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic note_mismatch(input string what, input bra_pkg::t_out want,
                                 input bra_pkg::t_out got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: exp used=%0b found=%0b start=%0d err=%0b",
                     $time, what, want.bit_used, want.found, want.run_start,
                     want.index_error,
                     "  got used=%0b found=%0b start=%0d err=%0b",
                     got.bit_used, got.found, got.run_start, got.index_error);
    endtask

    always @(posedge i_clk) begin : check_results
        bra_pkg::t_out want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result", '0, o_result);
            end else begin
                want = pending_results.pop_front();
                if (o_result.bit_used !== want.bit_used || o_result.found !== want.found ||
                    o_result.run_start !== want.run_start ||
                    o_result.index_error !== want.index_error)
                    note_mismatch("result mismatch", want, o_result);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done === 1'b1 || (psel && penable && pready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    task automatic test_reset_state();
        send_op(op_item(bra_pkg::OP_FIND, 0, 1'b0, 1024), 0);
        send_op(op_item(bra_pkg::OP_TEST, 1023, 1'b0, 0), pick_gap());
        send_op(op_item(bra_pkg::OP_FIND, 0, 1'b0, 1025), pick_gap());
        send_op(op_item(bra_pkg::OP_FIND, 0, 1'b0, 0), pick_gap());
        send_op(op_item(bra_pkg::OP_FIND, 1023, 1'b1, 2047), pick_gap());
    endtask

    task automatic test_bit_ops();
        send_op(op_item(bra_pkg::OP_WRITE, 0, 1'b1, 0), 0);
        send_op(op_item(bra_pkg::OP_WRITE, 1023, 1'b1, 2047), 0);
        send_op(op_item(bra_pkg::OP_TEST, 0, 1'b0, 0), 0);
        send_op(op_item(bra_pkg::OP_TEST, 1023, 1'b1, 0), 2);
        send_op(op_item(bra_pkg::OP_FIND, 0, 1'b0, 1022), 0);
        send_op(op_item(bra_pkg::OP_FIND, 0, 1'b0, 1023), 1);
        send_op(op_item(bra_pkg::OP_WRITE, 1023, 1'b0, 0), 0);
        send_op(op_item(bra_pkg::OP_TEST, 1023, 1'b0, 0), 0);
    endtask

    task automatic test_size_edges();
        int i;
        // no managed units at all
        write_bytes_in_use(8'd0);
        send_op(op_item(bra_pkg::OP_TEST, 5, 1'b0, 0), 0);
        send_op(op_item(bra_pkg::OP_WRITE, 5, 1'b1, 0), 0);
        send_op(op_item(bra_pkg::OP_FIND, 0, 1'b0, 1), 0);
        send_op(op_item(bra_pkg::OP_CLEAR, 0, 1'b0, 0), 0);
        // one byte: fill it so the full-byte skip runs into the bound
        write_bytes_in_use(8'd1);
        send_op(op_item(bra_pkg::OP_WRITE, 8, 1'b1, 0), 0);
        for (i = 1; i < 8; i++) send_op(op_item(bra_pkg::OP_WRITE, i, 1'b1, 0), 0);
        send_op(op_item(bra_pkg::OP_FIND, 0, 1'b0, 1), 0);
        write_bytes_in_use(8'd2);
        send_op(op_item(bra_pkg::OP_FIND, 0, 1'b0, 1), 0);
        // above the store size: saturates
        write_bytes_in_use(8'd255);
        send_op(op_item(bra_pkg::OP_TEST, 1023, 1'b0, 0), 0);
        send_op(op_item(bra_pkg::OP_FIND, 0, 1'b0, 1016), 0);
    endtask

    task automatic test_clear_scope();
        write_bytes_in_use(8'd128);
        send_op(op_item(bra_pkg::OP_WRITE, 1000, 1'b1, 0), 0);
        write_bytes_in_use(8'd4);
        send_op(op_item(bra_pkg::OP_CLEAR, 0, 1'b0, 0), 0);
        write_bytes_in_use(8'd128);
        send_op(op_item(bra_pkg::OP_TEST, 1000, 1'b0, 0), 0);
        send_op(op_item(bra_pkg::OP_TEST, 0, 1'b0, 0), 0);
    endtask

    task automatic test_random_mix();
        logic [7:0] sizes [11];
        int   p;
        int   n;
        int   units;
        int   density;
        int   r;
        int   idx;
        int   len;
        int   gap;
        logic steady;
        logic [1:0] op;
        sizes = '{8'd128, 8'd1, 8'd2, 8'd5, 8'd16, 8'd0, 8'd64, 8'd255, 8'd129,
                  8'($urandom_range(1, 128)), 8'($urandom_range(1, 128))};
        for (p = 0; p < 11; p++) begin
            write_bytes_in_use(sizes[p]);
            units = managed_bytes() * 8;
            density = $urandom_range(10, 95);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 25 == 0) steady = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                if (r < 3) op = bra_pkg::OP_CLEAR;
                else if (r < 23) op = bra_pkg::OP_TEST;
                else if (r < 63) op = bra_pkg::OP_WRITE;
                else op = bra_pkg::OP_FIND;
                if (units > 0 && $urandom_range(0, 9) < 8) idx = $urandom_range(0, units - 1);
                else idx = $urandom_range(0, 1023);
                r = $urandom_range(0, 99);
                if (r < 60) len = $urandom_range(1, (units > 16) ? 16 : ((units > 0) ? units : 1));
                else if (r < 80) len = $urandom_range(1, (units > 0) ? units : 1);
                else if (r < 90) len = units + $urandom_range(0, 1);
                else len = $urandom_range(0, 2047);
                gap = steady ? 0 : pick_gap();
                send_op(op_item(op, idx, ($urandom_range(0, 99) < density), len), gap);
            end
        end
    endtask

    initial begin
        for (int b = 0; b < MAP_BYTES; b++) usage_map[b] = 8'h00;
        bytes_reg = bra_pkg::BYTES_RESET;
        mismatches = 0;
        stall_cycles = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_bit_ops();
        test_size_edges();
        test_clear_scope();
        test_random_mix();

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
